FILE: src/wsrs_pkg.sv
package wsrs_pkg;

    // sizing of the deque store; the packed fields below are built for these
    localparam int DEQUE_SLOTS = 64;
    localparam int MAX_WORKERS = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  worker;
        logic [31:0] job_items;
        logic [31:0] job_grain;
        logic [31:0] finished_count;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  reply;
        logic [31:0] chunk_begin;
        logic [31:0] chunk_end;
        logic        was_stolen;
        logic [3:0]  victim_index;
        logic [31:0] items_left;
    } t_out_item;

    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;
    localparam logic [1:0] OP_REPORT   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] RP_NONE     = 3'd0;
    localparam logic [2:0] RP_GRANT    = 3'd1;
    localparam logic [2:0] RP_ACCEPT   = 3'd2;
    localparam logic [2:0] RP_BUSY     = 3'd3;
    localparam logic [2:0] RP_COMPLETE = 3'd4;
    localparam logic [2:0] RP_EMPTY    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RD_WAIT,
        S_RD_DATA,
        S_SPLIT,
        S_FLUSH,
        S_OUT
    } t_state;

    // memory request from the sequencer to the deque store
    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [63:0] wr_data;
    } t_mem_req;

endpackage

FILE: src/wsrs_store.sv
// Entry memory of all deques, one port, registered read
module wsrs_store #(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 576
) (
    input  logic                 i_clk,
    input  logic [ADDR_W-1:0]    i_addr,
    input  wsrs_pkg::t_mem_req   i_req,
    output logic [63:0]          o_rd_data
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/work_stealing_range_scheduler_top.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | i_valid / o_ready     | i_item  (wsrs_pkg::t_in_item)
// out     | output    | o_valid / i_ready     | o_item  (wsrs_pkg::t_out_item)
// cfg     | input     | i_cfg_we / i_cfg_data | active_workers, 4 bits
//
// One item at a time: it is taken in S_IDLE, decoded in S_DECODE and the result is
// then held in S_OUT. A request also checks the deques in S_SCAN, reads the entry
// found through S_RD_WAIT and S_RD_DATA, and in S_SPLIT pushes split halves and
// then forms the grant; the single memory port serialises these steps.
// A completing report clears the pointers of every deque in turn in S_FLUSH.
// Reset is synchronous, active low. A stalled output holds the result; no new item
// is taken until it leaves.
module work_stealing_range_scheduler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wsrs_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wsrs_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data
);

    localparam int DEQUE_SLOTS = wsrs_pkg::DEQUE_SLOTS;
    localparam int MAX_WORKERS = wsrs_pkg::MAX_WORKERS;
    localparam int NUM_DQ = MAX_WORKERS + 1;
    localparam int SLOT_W = $clog2(DEQUE_SLOTS);
    localparam int PTR_W  = SLOT_W + 1;
    localparam int DQ_W   = (NUM_DQ > 1) ? $clog2(NUM_DQ) : 1;
    localparam int ADDR_W = $clog2(NUM_DQ * DEQUE_SLOTS);
    localparam int DEPTH  = NUM_DQ * DEQUE_SLOTS;
    localparam int CNT_W  = 11;

    // control state
    wsrs_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0] r_bot [NUM_DQ];
    logic [PTR_W-1:0] r_top [NUM_DQ];
    logic [31:0]      r_remain, n_remain;
    logic             r_running, n_running;
    logic [31:0]      r_grain, n_grain;
    logic [3:0]       r_active;

    // item registers
    wsrs_pkg::t_in_item  r_in;
    wsrs_pkg::t_out_item r_out, n_out;
    logic [3:0]  r_cur, n_cur;        // deque being checked
    logic [CNT_W-1:0] r_off, n_off;   // scan offset
    logic [31:0] r_b, n_b, r_e, n_e;

    // pointer update bus
    logic             ptr_we;
    logic [DQ_W-1:0]  ptr_idx;
    logic [PTR_W-1:0] ptr_bot, ptr_top;
    logic             ptr_clr;

    wsrs_pkg::t_mem_req mem_req;
    logic [ADDR_W-1:0]  mem_addr;
    logic [63:0]        mem_rd;

    wsrs_store #(.ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_addr    (mem_addr),
        .i_req     (mem_req),
        .o_rd_data (mem_rd)
    );

    // derived values
    logic [4:0]       n_dq;
    logic [DQ_W-1:0]  cur_idx, req_idx, sub_idx;
    logic [PTR_W-1:0] cur_cnt, req_cnt, sub_cnt;
    logic [31:0]      span, mid;
    logic             stolen;

    assign n_dq    = {1'b0, r_active} + 5'd1;
    assign cur_idx = r_cur[DQ_W-1:0];
    assign req_idx = r_in.worker[DQ_W-1:0];
    assign sub_idx = r_active[DQ_W-1:0];
    assign cur_cnt = r_bot[cur_idx] - r_top[cur_idx];
    assign req_cnt = r_bot[req_idx] - r_top[req_idx];
    assign sub_cnt = r_bot[sub_idx] - r_top[sub_idx];
    assign span    = r_e - r_b;
    assign mid     = r_b + {1'b0, span[31:1]};
    assign stolen  = (r_off != '0);

    // configuration register with clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'(MAX_WORKERS);
        end else if (i_cfg_we) begin
            if (i_cfg_data == 4'd0) begin
                r_active <= 4'd1;
            end else if ({28'd0, i_cfg_data} > 32'(MAX_WORKERS)) begin
                r_active <= 4'(MAX_WORKERS);
            end else begin
                r_active <= i_cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wsrs_pkg::S_IDLE: begin
                if (i_valid) n_state = wsrs_pkg::S_DECODE;
            end
            wsrs_pkg::S_DECODE: begin
                case (r_in.op)
                    wsrs_pkg::OP_REQUEST: begin
                        if (r_running && ({1'b0, r_in.worker} < n_dq))
                            n_state = wsrs_pkg::S_SCAN;
                        else
                            n_state = wsrs_pkg::S_OUT;
                    end
                    wsrs_pkg::OP_REPORT: begin
                        if (r_running && (r_in.finished_count >= r_remain))
                            n_state = wsrs_pkg::S_FLUSH;
                        else
                            n_state = wsrs_pkg::S_OUT;
                    end
                    default: n_state = wsrs_pkg::S_OUT;
                endcase
            end
            wsrs_pkg::S_SCAN: begin
                if (cur_cnt != '0)
                    n_state = wsrs_pkg::S_RD_WAIT;
                else if ({1'b0, r_off} + 12'd1 >= {7'd0, n_dq})
                    n_state = wsrs_pkg::S_OUT;
            end
            wsrs_pkg::S_RD_WAIT: n_state = wsrs_pkg::S_RD_DATA;
            wsrs_pkg::S_RD_DATA: n_state = wsrs_pkg::S_SPLIT;
            wsrs_pkg::S_SPLIT: begin
                if (span <= r_grain || req_cnt >= PTR_W'(DEQUE_SLOTS))
                    n_state = wsrs_pkg::S_OUT;
            end
            wsrs_pkg::S_FLUSH: begin
                if ({1'b0, r_cur} + 5'd1 >= 5'(NUM_DQ)) n_state = wsrs_pkg::S_OUT;
            end
            wsrs_pkg::S_OUT: begin
                if (i_ready) n_state = wsrs_pkg::S_IDLE;
            end
            default: n_state = wsrs_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb begin
        logic [4:0] nxt;
        n_remain  = r_remain;
        n_running = r_running;
        n_grain   = r_grain;
        n_out     = r_out;
        n_cur     = r_cur;
        n_off     = r_off;
        n_b       = r_b;
        n_e       = r_e;
        ptr_we    = 1'b0;
        ptr_clr   = 1'b0;
        ptr_idx   = cur_idx;
        ptr_bot   = r_bot[cur_idx];
        ptr_top   = r_top[cur_idx];
        mem_req   = '0;
        mem_addr  = '0;
        nxt       = '0;
        case (r_state)
            wsrs_pkg::S_DECODE: begin
                n_out = '0;
                n_cur = r_in.worker;
                n_off = '0;
                case (r_in.op)
                    wsrs_pkg::OP_SUBMIT: begin
                        if (r_running) begin
                            n_out.reply = wsrs_pkg::RP_BUSY;
                        end else if (r_in.job_items == '0) begin
                            n_out.reply = wsrs_pkg::RP_EMPTY;
                        end else if (sub_cnt >= PTR_W'(DEQUE_SLOTS)) begin
                            n_out.reply = wsrs_pkg::RP_BUSY;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_data = {32'd0, r_in.job_items};
                            mem_addr = ADDR_W'(sub_idx * DEQUE_SLOTS)
                                     + ADDR_W'(r_bot[sub_idx][SLOT_W-1:0]);
                            ptr_we  = 1'b1;
                            ptr_idx = sub_idx;
                            ptr_bot = r_bot[sub_idx] + 1'b1;
                            ptr_top = r_top[sub_idx];
                            n_grain = (r_in.job_grain == '0) ? 32'd1 : r_in.job_grain;
                            n_remain  = r_in.job_items;
                            n_running = 1'b1;
                            n_out.reply = wsrs_pkg::RP_ACCEPT;
                        end
                    end
                    wsrs_pkg::OP_REPORT: begin
                        if (r_running) begin
                            if (r_in.finished_count >= r_remain) begin
                                n_remain  = '0;
                                n_running = 1'b0;
                                n_out.reply = wsrs_pkg::RP_COMPLETE;
                                n_cur = '0;
                            end else begin
                                n_remain = r_remain - r_in.finished_count;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            wsrs_pkg::S_SCAN: begin
                if (cur_cnt != '0) begin
                    ptr_we = 1'b1;
                    mem_req.rd_en = 1'b1;
                    if (!stolen) begin
                        ptr_bot  = r_bot[cur_idx] - 1'b1;
                        mem_addr = ADDR_W'(cur_idx * DEQUE_SLOTS)
                                 + ADDR_W'(ptr_bot[SLOT_W-1:0]);
                    end else begin
                        ptr_top  = r_top[cur_idx] + 1'b1;
                        mem_addr = ADDR_W'(cur_idx * DEQUE_SLOTS)
                                 + ADDR_W'(r_top[cur_idx][SLOT_W-1:0]);
                    end
                end else begin
                    n_off = r_off + 1'b1;
                    nxt   = {1'b0, r_cur} + 5'd1;
                    if (nxt >= n_dq) nxt = nxt - n_dq;
                    n_cur = nxt[3:0];
                end
            end
            wsrs_pkg::S_RD_DATA: begin
                n_b = mem_rd[63:32];
                n_e = mem_rd[31:0];
            end
            wsrs_pkg::S_SPLIT: begin
                if (span > r_grain && req_cnt < PTR_W'(DEQUE_SLOTS)) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = {mid, r_e};
                    mem_addr = ADDR_W'(req_idx * DEQUE_SLOTS)
                             + ADDR_W'(r_bot[req_idx][SLOT_W-1:0]);
                    ptr_we  = 1'b1;
                    ptr_idx = req_idx;
                    ptr_bot = r_bot[req_idx] + 1'b1;
                    ptr_top = r_top[req_idx];
                    n_e = mid;
                end else begin
                    n_out.reply        = wsrs_pkg::RP_GRANT;
                    n_out.chunk_begin  = r_b;
                    n_out.chunk_end    = r_e;
                    n_out.was_stolen   = stolen;
                    n_out.victim_index = r_cur;
                end
            end
            wsrs_pkg::S_FLUSH: begin
                ptr_we  = 1'b1;
                ptr_clr = 1'b1;
                n_cur   = r_cur + 4'd1;
            end
            default: ;
        endcase
        n_out.items_left = n_remain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wsrs_pkg::S_IDLE;
            r_remain  <= '0;
            r_running <= 1'b0;
            r_grain   <= 32'd1;
            for (int i = 0; i < NUM_DQ; i++) begin
                r_bot[i] <= '0;
                r_top[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_remain  <= n_remain;
            r_running <= n_running;
            r_grain   <= n_grain;
            if (ptr_we) begin
                r_bot[ptr_idx] <= ptr_clr ? '0 : ptr_bot;
                r_top[ptr_idx] <= ptr_clr ? '0 : ptr_top;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == wsrs_pkg::S_IDLE && i_valid) r_in <= i_item;
        r_out <= n_out;
        r_cur <= n_cur;
        r_off <= n_off;
        r_b   <= n_b;
        r_e   <= n_e;
    end

    assign o_ready = (r_state == wsrs_pkg::S_IDLE);
    assign o_valid = (r_state == wsrs_pkg::S_OUT);
    assign o_item  = r_out;

endmodule
